// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TRM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TRM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TRM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TRM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/trm_pkg.sv =====
package trm_pkg;

  localparam int unsigned TOT_W  = 48;
  localparam int unsigned AVG_W  = 40;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned Q8_W   = 9;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned CNT_W  = 6;

  localparam logic [CNT_W-1:0] CNT_LAST  = 6'd47;
  localparam logic [CNT_W-1:0] CNT_AVG   = 6'd40;
  localparam logic [CNT_W-1:0] CNT_DELTA = 6'd32;
  localparam logic [CNT_W-1:0] CNT_FRAC  = 6'd8;

  localparam logic [Q8_W-1:0] Q8_ONE   = 9'd256;
  localparam logic [Q8_W-1:0] Q8_RESET = 9'd230;

  localparam logic CFG_SAMPLE_WEIGHT = 1'b0;
  localparam logic CFG_PEAK_DECAY    = 1'b1;

  typedef logic [Q8_W-1:0] q8_t;

  typedef struct packed {
    logic             operation;
    logic             link_up;
    logic             counters_valid;
    logic [TOT_W-1:0] rx_total;
    logic [TOT_W-1:0] tx_total;
  } trm_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] rx_rate_out;
    logic [RATE_W-1:0] tx_rate_out;
    logic [LVL_W-1:0]  rx_level;
    logic [LVL_W-1:0]  tx_level;
    logic              link_active;
    logic              refresh;
  } trm_out_t;

  typedef struct packed {
    logic op;
    logic up;
    logic valid;
  } trm_cmd_t;

  typedef struct packed {
    logic             idle;
    logic             load;
    logic             sub;
    logic             smo;
    logic             pk;
    logic             div;
    logic             last;
    logic             wr;
    logic [CNT_W-1:0] cnt;
  } trm_ctl_t;

endpackage

// ===== hw/rtl/trm_ctrl.sv =====
module trm_ctrl import trm_pkg::*; #(
  parameter int unsigned LEVELS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     out_free_i,
  output trm_ctl_t ctl_o
);

  localparam int unsigned QB  = $clog2(LEVELS);
  localparam int unsigned ITW = (QB > 1) ? $clog2(QB) : 1;
  localparam logic [ITW-1:0] IT_LAST = ITW'(QB - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_SMO,
    S_PK,
    S_DIV,
    S_WAIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ITW-1:0]   it_q;
  logic             last;

  assign last = (cnt_q == CNT_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      it_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (start_i) begin
            state_q <= S_SUB;
          end
        end
        S_SUB: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          if (last) begin
            state_q <= S_SMO;
          end
        end
        S_SMO: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          if (last) begin
            state_q <= S_PK;
          end
        end
        S_PK: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          it_q  <= '0;
          if (last) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          if (last) begin
            if (it_q == IT_LAST) begin
              state_q <= S_WAIT;
            end else begin
              it_q <= it_q + 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign ctl_o.idle = (state_q == S_IDLE);
  assign ctl_o.load = (state_q == S_IDLE) && start_i;
  assign ctl_o.sub  = (state_q == S_SUB);
  assign ctl_o.smo  = (state_q == S_SMO);
  assign ctl_o.pk   = (state_q == S_PK);
  assign ctl_o.div  = (state_q == S_DIV);
  assign ctl_o.last = last;
  assign ctl_o.wr   = (state_q == S_WAIT) && out_free_i;
  assign ctl_o.cnt  = cnt_q;

endmodule

// ===== hw/rtl/trm_lane.sv =====
module trm_lane import trm_pkg::*; #(
  parameter int unsigned LEVELS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trm_ctl_t          ctl_i,
  input  trm_cmd_t          cmd_i,
  input  q8_t               w_i,
  input  q8_t               wb_i,
  input  q8_t               d_i,
  input  logic [TOT_W-1:0]  total_i,
  output logic [RATE_W-1:0] rate_o,
  output logic [LVL_W-1:0]  level_o,
  output logic              peak_nz_o
);

  localparam int unsigned QB = $clog2(LEVELS);
  localparam logic [LVL_W-1:0] LMAX = LVL_W'(LEVELS - 1);

  // state
  logic [TOT_W-1:0] base_q;
  logic [AVG_W-1:0] av_q;
  logic [AVG_W-1:0] pk_q;

  // serial working registers
  logic [TOT_W-1:0] tot_q;
  logic [AVG_W-1:0] dl_q;
  logic [AVG_W-1:0] nav_q;
  logic [AVG_W-1:0] dec_q;
  logic [TOT_W-1:0] nr_q;
  logic [TOT_W-1:0] dv_q;
  logic [TOT_W-1:0] df_q;
  logic             brw_q;
  logic             hi_q;
  logic             ge_q;
  logic             ge2_q;
  logic [Q8_W-1:0]  acc_a_q;
  logic [Q8_W-1:0]  acc_p_q;
  logic [LVL_W-1:0] acc_n_q;
  logic [LVL_W-1:0] q_q;

  logic             lo40, lo32, hi8;
  logic             sa, sb, diff, brw_d, hi_d, upd;
  logic             dbit, abit, pbit, nbit, pkbit, dcbit;
  logic [Q8_W:0]    sum_a, sum_p;
  logic [LVL_W:0]   sum_n;
  logic [AVG_W-1:0] pk_nx;

  assign lo40 = (ctl_i.cnt < CNT_AVG);
  assign lo32 = (ctl_i.cnt < CNT_DELTA);
  assign hi8  = (ctl_i.cnt >= CNT_FRAC);

  // one serial subtractor, shared by the delta and the divide steps
  assign sa    = ctl_i.sub ? tot_q[0] : nr_q[0];
  assign sb    = ctl_i.sub ? base_q[0] : dv_q[0];
  assign diff  = sa ^ sb ^ brw_q;
  assign brw_d = (~sa & sb) | (~(sa ^ sb) & brw_q);
  assign hi_d  = hi_q | diff;
  assign upd   = cmd_i.valid && (cmd_i.op || cmd_i.up);

  assign dbit  = lo40 && dl_q[0];
  assign abit  = lo40 && av_q[0];
  assign pbit  = lo40 && pk_q[0];
  assign nbit  = lo40 && nav_q[0];
  assign pkbit = pk_q[0];
  assign dcbit = dec_q[0];

  assign sum_a = (Q8_W+1)'(acc_a_q) + (dbit ? (Q8_W+1)'(w_i) : '0)
               + (abit ? (Q8_W+1)'(wb_i) : '0);
  assign sum_p = (Q8_W+1)'(acc_p_q) + (pbit ? (Q8_W+1)'(d_i) : '0);
  assign sum_n = (LVL_W+1)'(acc_n_q) + (nbit ? (LVL_W+1)'(LMAX) : '0);

  assign pk_nx = ge_q ? nav_q : dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      av_q   <= '0;
      pk_q   <= '0;
    end else if (ctl_i.load) begin
      if (cmd_i.op) begin
        av_q <= '0;
        pk_q <= '0;
      end
    end else if (ctl_i.sub) begin
      if (ctl_i.last && upd) begin
        base_q <= {tot_q[0], tot_q[TOT_W-1:1]};
      end else begin
        base_q <= {base_q[0], base_q[TOT_W-1:1]};
      end
    end else if (ctl_i.smo) begin
      if (lo40) begin
        av_q <= {av_q[0], av_q[AVG_W-1:1]};
        pk_q <= {pk_q[0], pk_q[AVG_W-1:1]};
      end
    end else if (ctl_i.pk) begin
      if (ctl_i.last) begin
        av_q <= cmd_i.up ? nav_q : '0;
        pk_q <= cmd_i.up ? pk_nx : '0;
      end else if (lo40) begin
        pk_q <= {pk_q[0], pk_q[AVG_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      tot_q   <= total_i;
      dl_q    <= '0;
      hi_q    <= 1'b0;
      brw_q   <= 1'b0;
      acc_a_q <= '0;
      acc_p_q <= '0;
      acc_n_q <= '0;
      ge_q    <= 1'b1;
      ge2_q   <= 1'b1;
      q_q     <= '0;
    end else if (ctl_i.sub) begin
      tot_q <= {tot_q[0], tot_q[TOT_W-1:1]};
      brw_q <= ctl_i.last ? 1'b0 : brw_d;
      if (lo32) begin
        dl_q <= {diff, dl_q[AVG_W-1:1]};
      end else begin
        hi_q <= hi_d;
      end
      if (ctl_i.last) begin
        if (cmd_i.op) begin
          dl_q[AVG_W-1:FRAC_W] <= '0;
        end else if (hi_d) begin
          dl_q[AVG_W-1:FRAC_W] <= '1;
        end
      end
    end else if (ctl_i.smo) begin
      if (lo40) begin
        dl_q <= {dl_q[0], dl_q[AVG_W-1:1]};
      end
      acc_a_q <= sum_a[Q8_W:1];
      acc_p_q <= sum_p[Q8_W:1];
      if (hi8) begin
        nav_q <= {sum_a[0], nav_q[AVG_W-1:1]};
        dec_q <= {sum_p[0], dec_q[AVG_W-1:1]};
      end
    end else if (ctl_i.pk) begin
      if (lo40) begin
        nav_q <= {nav_q[0], nav_q[AVG_W-1:1]};
        dec_q <= {dec_q[0], dec_q[AVG_W-1:1]};
        if (nbit != pkbit) begin
          ge_q <= nbit;
        end
        if (nbit != dcbit) begin
          ge2_q <= nbit;
        end
      end
      acc_n_q <= sum_n[LVL_W:1];
      nr_q    <= {sum_n[0], nr_q[TOT_W-1:1]};
      if (ctl_i.last) begin
        dv_q <= TOT_W'(pk_nx) << (QB - 1);
      end
    end else if (ctl_i.div) begin
      df_q <= {diff, df_q[TOT_W-1:1]};
      if (ctl_i.last) begin
        brw_q <= 1'b0;
        nr_q  <= brw_d ? {nr_q[0], nr_q[TOT_W-1:1]} : {diff, df_q[TOT_W-1:1]};
        dv_q  <= {1'b0, dv_q[0], dv_q[TOT_W-1:2]};
        q_q   <= {q_q[LVL_W-2:0], ~brw_d};
      end else begin
        brw_q <= brw_d;
        nr_q  <= {nr_q[0], nr_q[TOT_W-1:1]};
        dv_q  <= {dv_q[0], dv_q[TOT_W-1:1]};
      end
    end
  end

  assign rate_o    = av_q[AVG_W-1:FRAC_W];
  assign peak_nz_o = |pk_q;
  assign level_o   = !peak_nz_o ? '0 : ((ge_q || ge2_q) ? LMAX : q_q);

endmodule

// ===== hw/rtl/traffic_rate_meter.sv =====
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   in_data_i   (trm_in_t)
// out      out  out_valid_o / out_stall_i out_data_o  (trm_out_t)
// cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item at a time: delta, smoothing and peak steps, then one divider pass
// per quotient bit ($clog2(LEVELS) bits) in the bit-serial divider. Result
// is registered in the final step; next item can be taken the cycle after.
// Reset clears baselines, averages, peaks, out_valid; weights go to Q8_RESET.
// A stalled result holds the block in its final step until taken.
`include "assert_macros.svh"

module traffic_rate_meter import trm_pkg::*; #(
  parameter int unsigned LEVELS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  trm_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output trm_out_t        out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [Q8_W-1:0] cfg_data_i
);

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

  trm_ctl_t          ctl;
  trm_cmd_t          cmd, cmd_q;
  q8_t               sw_q, pd_q, w_c, w_eff, wb, d_c;
  logic              was_up_q, out_valid_q, out_free;
  trm_out_t          out_q;
  logic [RATE_W-1:0] rx_rate, tx_rate;
  logic [LVL_W-1:0]  rx_lvl, tx_lvl;
  logic              rx_nz, tx_nz, refresh;
  logic              lvl_ok, down_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= Q8_RESET;
      pd_q <= Q8_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_WEIGHT: sw_q <= cfg_data_i;
        CFG_PEAK_DECAY:    pd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_c   = (sw_q > Q8_ONE) ? Q8_ONE : sw_q;
  assign d_c   = (pd_q > Q8_ONE) ? Q8_ONE : pd_q;
  assign w_eff = cmd.valid ? w_c : '0;
  assign wb    = Q8_ONE - w_eff;

  assign in_stall_o = !ctl.idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cmd = ctl.load ? trm_cmd_t'{op: in_data_i.operation, up: in_data_i.link_up,
                                     valid: in_data_i.counters_valid} : cmd_q;

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      cmd_q <= cmd;
    end
  end

  trm_ctrl #(.LEVELS(LEVELS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  trm_lane #(.LEVELS(LEVELS)) u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .cmd_i     (cmd),
    .w_i       (w_eff),
    .wb_i      (wb),
    .d_i       (d_c),
    .total_i   (in_data_i.rx_total),
    .rate_o    (rx_rate),
    .level_o   (rx_lvl),
    .peak_nz_o (rx_nz)
  );

  trm_lane #(.LEVELS(LEVELS)) u_tx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .cmd_i     (cmd),
    .w_i       (w_eff),
    .wb_i      (wb),
    .d_i       (d_c),
    .total_i   (in_data_i.tx_total),
    .rate_o    (tx_rate),
    .level_o   (tx_lvl),
    .peak_nz_o (tx_nz)
  );

  assign refresh = cmd_q.up ? (!was_up_q || rx_nz || tx_nz) : was_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      was_up_q    <= 1'b0;
    end else begin
      if (ctl.wr) begin
        out_valid_q <= 1'b1;
        was_up_q    <= cmd_q.up;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.wr) begin
      out_q.rx_rate_out <= rx_rate;
      out_q.tx_rate_out <= tx_rate;
      out_q.rx_level    <= rx_lvl;
      out_q.tx_level    <= tx_lvl;
      out_q.link_active <= cmd_q.up;
      out_q.refresh     <= refresh;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lvl_ok    = (out_q.rx_level <= LVL_MAX) && (out_q.tx_level <= LVL_MAX);
  assign down_zero = (out_q.rx_rate_out == '0) && (out_q.tx_rate_out == '0)
                  && (out_q.rx_level == '0) && (out_q.tx_level == '0);

  `TRM_ASSERT_IMP(a_wr_free, clk_i, rst_ni, ctl.wr, !(out_valid_q && out_stall_i))
  `TRM_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, ctl.load, in_stall_o)
  `TRM_ASSERT_IMP(a_level_range, clk_i, rst_ni, out_valid_q, lvl_ok)
  `TRM_ASSERT_IMP(a_down_zero, clk_i, rst_ni, out_valid_q && !out_q.link_active, down_zero)

endmodule
